/* rtl/core/file_directory_table_top_assert.svh */
// Assertion macros used by the directory top
`ifndef FILE_DIRECTORY_TABLE_TOP_ASSERT_SVH
`define FILE_DIRECTORY_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define FDT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("directory assertion failed");

// next-cycle implication
`define FDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("directory assertion failed");

`endif

/* rtl/core/fdt_pkg.sv */
package fdt_pkg;

  localparam int KEY_W  = 64;
  localparam int SIZE_W = 16;
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_FIND    = 2'd1,
    MODE_REMOVE  = 2'd2,
    MODE_SETSIZE = 2'd3
  } fdt_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_MISSING = 2'd3
  } fdt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ACT
  } fdt_state_t;

  typedef struct packed {
    logic              name_we;
    logic              size_we;
    logic [KEY_W-1:0]  name;
    logic [SIZE_W-1:0] size;
  } fdt_wr_t;

endpackage

/* rtl/core/fdt_store.sv */
module fdt_store
  import fdt_pkg::*;
#(
  parameter int ENTRIES = 15,
  parameter int IDX_W   = 4
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [KEY_W-1:0]  rd_name,
  output logic [SIZE_W-1:0] rd_size,
  input  logic [IDX_W-1:0]  wr_addr,
  input  fdt_wr_t           wr
);

  logic [KEY_W-1:0]  name_mem [ENTRIES];
  logic [SIZE_W-1:0] size_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.name_we) begin
      name_mem[wr_addr] <= wr.name;
    end
    if (wr.size_we) begin
      size_mem[wr_addr] <= wr.size;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_name <= name_mem[rd_addr];
      rd_size <= size_mem[rd_addr];
    end
  end

endmodule

/* rtl/core/file_directory_table_top.sv */
// File directory table.
// Input channel (in_valid/in_ready) takes one command beat: in_mode selects
// create, find, remove or set size, in_name_key is the NUL-padded name and
// in_new_size the size for set size. Each command yields exactly one result
// beat on the output channel (out_valid/out_ready): out_status, out_slot and
// out_entry_size.
// A command scans every slot through one name comparator, one slot per
// cycle from the name/size memory (registered read). The result becomes
// valid in the same cycle that in_ready rises again, so a new command is
// taken only after the last one has passed its scan, drain and act steps;
// the slot scan sets the command rate.
// Reset (synchronous, rst_n low) clears all used flags and leaves the
// directory empty; no clearing pass is needed, names and sizes are only
// read from used slots.
// If the receiver stalls, the finished result holds in the output register.
// A following command is still accepted and scanned; its sequencer then
// waits at its final step, before touching the table, until that result
// has gone.
module file_directory_table_top
  import fdt_pkg::*;
#(
  parameter int ENTRIES    = 15,
  parameter int NAME_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [KEY_W-1:0]  in_name_key,
  input  logic [SIZE_W-1:0] in_new_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [SIZE_W-1:0] out_entry_size
);

`include "file_directory_table_top_assert.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  fdt_state_t state_r, state_nxt;

  fdt_mode_t         mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] new_size_r;
  logic [KEY_W-1:0]  key_norm;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r, hit_nxt, free_r, free_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [SIZE_W-1:0] hit_size_r, hit_size_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;

  logic              out_valid_r;
  fdt_status_t       out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [SIZE_W-1:0] out_entry_size_r;

  logic [KEY_W-1:0]  rd_name;
  logic [SIZE_W-1:0] rd_size;
  logic              rd_en;
  logic              accept, act_go, match;

  fdt_wr_t           wr;
  fdt_status_t       res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [SIZE_W-1:0] res_size;
  logic              set_used, clr_used;

  // keep bytes up to the first NUL and below NAME_BYTES
  always_comb begin
    logic alive;
    alive    = 1'b1;
    key_norm = '0;
    for (int i = 0; i < 8; i++) begin
      alive = alive && (in_name_key[8*i +: 8] != 8'h00) && (i < NAME_BYTES);
      if (alive) begin
        key_norm[8*i +: 8] = in_name_key[8*i +: 8];
      end
    end
  end

  fdt_store #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_name (rd_name),
    .rd_size (rd_size),
    .wr_addr (res_idx),
    .wr      (wr)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_ACT;
      S_ACT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    act_go   = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  rd_en    = 1'b1;
      S_DRAIN: ;
      S_ACT:   act_go   = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign match  = cmp_vld_r && used_r[cmp_idx_r] && (rd_name == key_r);

  // scan bookkeeping
  always_comb begin
    idx_nxt      = rd_en ? idx_r + IDX_W'(1) : idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_size_nxt = hit_size_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    if (accept) begin
      idx_nxt  = '0;
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (cmp_vld_r) begin
      if (match && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_idx_nxt  = cmp_idx_r;
        hit_size_nxt = rd_size;
      end
      if (!used_r[cmp_idx_r] && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end
  end

  // command result and table update
  always_comb begin
    res_status = ST_OK;
    res_idx    = hit_idx_r;
    res_size   = hit_size_r;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    wr         = '0;
    wr.name    = key_r;
    case (mode_r)
      MODE_CREATE: begin
        res_idx  = free_idx_r;
        res_size = '0;
        if (hit_r) begin
          res_status = ST_EXISTS;
        end else if (!free_r) begin
          res_status = ST_FULL;
        end else begin
          set_used   = 1'b1;
          wr.name_we = 1'b1;
          wr.size_we = 1'b1;
        end
      end
      MODE_REMOVE: begin
        res_size = '0;
        if (hit_r) begin
          clr_used   = 1'b1;
          wr.size_we = 1'b1;
        end
      end
      MODE_SETSIZE: begin
        res_size = new_size_r;
        if (hit_r) begin
          wr.size_we = 1'b1;
          wr.size    = new_size_r;
        end
      end
      default: ;
    endcase
    if (mode_r != MODE_CREATE && !hit_r) begin
      res_status = ST_MISSING;
    end
    if (res_status != ST_OK) begin
      res_idx  = '0;
      res_size = '0;
    end
    if (!act_go) begin
      set_used = 1'b0;
      clr_used = 1'b0;
      wr.name_we = 1'b0;
      wr.size_we = 1'b0;
    end
    used_nxt = used_r;
    if (set_used) used_nxt[res_idx] = 1'b1;
    if (clr_used) used_nxt[res_idx] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      cmp_vld_r <= rd_en;
      if (act_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= fdt_mode_t'(in_mode);
      key_r      <= key_norm;
      new_size_r <= in_new_size;
    end
    cmp_idx_r  <= idx_r;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_size_r <= hit_size_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    if (act_go) begin
      out_status_r     <= res_status;
      out_slot_r       <= SLOT_W'(res_idx);
      out_entry_size_r <= res_size;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_entry_size = out_entry_size_r;

  `FDT_ASSERT_NOW(a_no_cmp_idle, accept, !cmp_vld_r)
  `FDT_ASSERT_NOW(a_hit_used, state_r == S_ACT && hit_r, used_r[hit_idx_r])
  `FDT_ASSERT_NEXT(a_create_sets, set_used, used_r[$past(res_idx)] && out_status_r == ST_OK)
  `FDT_ASSERT_NEXT(a_one_change, 1'b1,
                   $countones(used_r) <= $past($countones(used_r)) + 1)

endmodule

/* tb/testbench.sv */
module testbench;
  import fdt_pkg::*;

  localparam int ENTRIES    = 15;
  localparam int NAME_BYTES = 8;
  localparam int RANDOM_OPS = 700;
  localparam int POOL_SIZE  = 20;
  localparam int CYCLE_CAP  = 200000;

  typedef struct packed {
    fdt_status_t       status;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
  } dir_result_t;

  typedef struct {
    fdt_mode_t         mode;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] nsize;
    bit                typed;
    dir_result_t       want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_mode = MODE_FIND;
  logic [KEY_W-1:0]  in_name_key = '0;
  logic [SIZE_W-1:0] in_new_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [SIZE_W-1:0] out_entry_size;

  // directory image kept by the predictor
  bit               dir_used [ENTRIES];
  bit [KEY_W-1:0]   dir_name [ENTRIES];
  bit [SIZE_W-1:0]  dir_size [ENTRIES];

  dir_result_t pending_results[$];
  dir_row_t    script[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  file_directory_table_top #(
    .ENTRIES   (ENTRIES),
    .NAME_BYTES(NAME_BYTES)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_name_key   (in_name_key),
    .in_new_size   (in_new_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_entry_size(out_entry_size)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // bytes from the first NUL on are dropped
  function automatic logic [KEY_W-1:0] name_trim(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] r;
    bit stop;
    r = '0;
    stop = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (raw[8*i +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*i +: 8] = raw[8*i +: 8];
    end
    return r;
  endfunction

  function automatic dir_result_t dir_apply(fdt_mode_t m, logic [KEY_W-1:0] raw,
                                            logic [SIZE_W-1:0] nsize);
    dir_result_t r;
    logic [KEY_W-1:0] k;
    int hit;
    int free_slot;
    r.status = ST_OK;
    r.slot = '0;
    r.size = '0;
    k = name_trim(raw);
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && dir_used[i] && dir_name[i] == k) hit = i;
      if (free_slot < 0 && !dir_used[i]) free_slot = i;
    end
    if (m == MODE_CREATE) begin
      if (hit >= 0) begin
        r.status = ST_EXISTS;
      end else if (free_slot < 0) begin
        r.status = ST_FULL;
      end else begin
        dir_used[free_slot] = 1'b1;
        dir_name[free_slot] = k;
        dir_size[free_slot] = '0;
        r.slot = SLOT_W'(free_slot);
      end
    end else if (hit < 0) begin
      r.status = ST_MISSING;
    end else begin
      if (m == MODE_REMOVE) begin
        dir_used[hit] = 1'b0;
        dir_size[hit] = '0;
      end else if (m == MODE_SETSIZE) begin
        dir_size[hit] = nsize;
      end
      r.slot = SLOT_W'(hit);
      r.size = dir_size[hit];
    end
    return r;
  endfunction

  function automatic void add_row(fdt_mode_t m, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] n,
                                  bit typed, fdt_status_t st, logic [SLOT_W-1:0] sl,
                                  logic [SIZE_W-1:0] sz);
    dir_row_t row;
    row.mode = m;
    row.key = k;
    row.nsize = n;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = sl;
    row.want.size = sz;
    script.push_back(row);
  endfunction

  task automatic send_command(fdt_mode_t m, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] n,
                              bit typed, dir_result_t want);
    int gap;
    dir_result_t model;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_name_key <= k;
    in_new_size <= n;
    do @(posedge clk); while (!in_ready);
    model = dir_apply(m, k, n);
    pending_results.push_back(typed ? want : model);
  endtask

  // stimulus
  initial begin
    logic [KEY_W-1:0]  name_pool [POOL_SIZE];
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] nsize;
    fdt_mode_t         m;
    dir_result_t       none;
    int                len;
    int                r;
    int                cthr;
    none = '0;

    add_row(MODE_FIND,    64'h0000_0000_0000_6261, '0, 1'b1, ST_MISSING, '0, '0);
    add_row(MODE_REMOVE,  64'h0, '0, 1'b1, ST_MISSING, '0, '0);
    add_row(MODE_SETSIZE, 64'h0, 16'h1234, 1'b1, ST_MISSING, '0, '0);
    add_row(MODE_CREATE,  64'h0, 16'hFFFF, 1'b1, ST_OK, '0, '0);
    add_row(MODE_CREATE,  64'hFFFF_FFFF_FFFF_FF00, '0, 1'b1, ST_EXISTS, '0, '0);
    add_row(MODE_FIND,    64'h0123_4567_89AB_CD00, '0, 1'b1, ST_OK, '0, '0);
    add_row(MODE_SETSIZE, 64'h0000_0000_0000_5A00, 16'hFFFF, 1'b1, ST_OK, '0, 16'hFFFF);
    add_row(MODE_CREATE,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b1, ST_OK, 4'd1, '0);
    add_row(MODE_CREATE,  64'hDEAD_BEEF_0000_6261, '0, 1'b0, ST_OK, '0, '0);
    add_row(MODE_FIND,    64'h0000_0000_0000_6261, '0, 1'b0, ST_OK, '0, '0);
    for (int i = 0; i < 12; i++)
      add_row(MODE_CREATE, KEY_W'(8'h41 + i), '0, 1'b0, ST_OK, '0, '0);
    add_row(MODE_CREATE,  64'h0000_0000_0000_007A, '0, 1'b1, ST_FULL, '0, '0);
    add_row(MODE_REMOVE,  64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b1, ST_OK, 4'd1, '0);
    add_row(MODE_CREATE,  64'h0000_0000_0000_007A, '0, 1'b0, ST_OK, '0, '0);

    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int p = 2; p < POOL_SIZE; p++) begin
      name_pool[p] = '0;
      len = $urandom_range(1, NAME_BYTES);
      for (int b = 0; b < len; b++) name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      send_command(script[i].mode, script[i].key, script[i].nsize, script[i].typed,
                   script[i].want);

    cthr = 55;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      // swing between filling and draining the table
      if (n % 64 == 0) cthr = (cthr == 55) ? 15 : 55;
      r = $urandom_range(0, 99);
      if (r < cthr) m = MODE_CREATE;
      else if (r < cthr + (100 - cthr) / 3) m = MODE_FIND;
      else if (r < cthr + 2 * (100 - cthr) / 3) m = MODE_REMOVE;
      else m = MODE_SETSIZE;

      if ($urandom_range(0, 9) == 0) begin
        key = {$urandom, $urandom};
      end else begin
        key = name_pool[$urandom_range(0, POOL_SIZE - 1)];
        len = 0;
        while (len < 8 && key[8*len +: 8] != 8'h00) len++;
        if (len < 7 && $urandom_range(0, 1) == 1)
          for (int b = len + 1; b < 8; b++) key[8*b +: 8] = 8'($urandom);
      end

      case ($urandom_range(0, 7))
        0: nsize = '0;
        1: nsize = '1;
        default: nsize = 16'($urandom);
      endcase

      send_command(m, key, nsize, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side
  initial begin
    dir_result_t want;
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pause_len();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected (status %0d slot %0d size %0d)",
                 $time, out_status, out_slot, out_entry_size);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
        end
        if (out_slot !== want.slot) begin
          errors++;
          $display("%0t: slot expected %0d got %0d", $time, want.slot, out_slot);
        end
        if (out_entry_size !== want.size) begin
          errors++;
          $display("%0t: size expected %0h got %0h", $time, want.size, out_entry_size);
        end
      end
    end
  end

endmodule

/* file_directory_table_top.f */
+incdir+rtl/core
rtl/core/fdt_pkg.sv
rtl/core/fdt_store.sv
rtl/core/file_directory_table_top.sv
tb/testbench.sv
